### rtl/tnm_pkg.sv
package tnm_pkg;

    // weight store geometry
    localparam int MAX_INPUTS = 64;
    localparam int ADDR_W     = $clog2(MAX_INPUTS);

    // tanh table: TANH_N segments over [0, 4), TANH_N + 1 knots
    localparam int TANH_LOG2 = 8;
    localparam int TANH_N    = 1 << TANH_LOG2;
    localparam int SEG_W     = TANH_LOG2 + 1;
    localparam int TAB_W     = 13;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 28;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // op codes
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_FWD    = 3'd1;
    localparam logic [2:0] OP_OGRAD  = 3'd2;
    localparam logic [2:0] OP_HGRAD  = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ACT    = 2'd0;
    localparam logic [1:0] KIND_GRAD   = 2'd1;
    localparam logic [1:0] KIND_WEIGHT = 2'd2;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_MAC,
        S_ACC,
        S_TSEG,
        S_TA,
        S_TB,
        S_TMUL,
        S_TOUT,
        S_RND,
        S_SQ,
        S_OMS,
        S_GMUL,
        S_GOUT,
        S_XG,
        S_LR,
        S_MOM,
        S_DADD,
        S_WB
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic signed [15:0] weight;
        logic signed [15:0] change;
    } t_mem_req;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef logic [TAB_W-1:0] t_tanh_tab [0:TANH_N];

    // restoring quotient, only used while the table is built at elaboration
    function automatic logic [63:0] tab_quot(input logic [63:0] num,
                                             input logic [63:0] dvs);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, dvs}) begin
                rem  = rem - {1'b0, dvs};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4i/N) in Q3.12, from exp(-2x) as a 7th-order series of exp(-x/32) raised to the 64th
    function automatic t_tanh_tab tanh_table();
        t_tanh_tab   tab;
        logic [63:0] v;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] den;
        for (int i = 0; i <= TANH_N; i++) begin
            v = ((64'(i) << 30) + 64'(4 * TANH_N)) / 64'(8 * TANH_N);
            t = ONE_Q30;
            e = ONE_Q30;
            t = ((t * v) >> 30) / 64'd1;
            e = e - t;
            t = ((t * v) >> 30) / 64'd2;
            e = e + t;
            t = ((t * v) >> 30) / 64'd3;
            e = e - t;
            t = ((t * v) >> 30) / 64'd4;
            e = e + t;
            t = ((t * v) >> 30) / 64'd5;
            e = e - t;
            t = ((t * v) >> 30) / 64'd6;
            e = e + t;
            t = ((t * v) >> 30) / 64'd7;
            e = e - t;
            for (int r = 0; r < 6; r++) begin
                e = (e * e + (ONE_Q30 >> 1)) >> 30;
            end
            den    = ONE_Q30 + e;
            tab[i] = TAB_W'(tab_quot(64'd8192 * (ONE_Q30 - e) + den, den << 1));
        end
        return tab;
    endfunction

    localparam t_tanh_tab TANH_TAB = tanh_table();

endpackage

### rtl/tnm_mul.sv
module tnm_mul (
    input  logic                             i_clk,
    input  tnm_pkg::t_mul_req                i_req,
    output logic signed [tnm_pkg::MUL_P_W-1:0] o_prod
);
    import tnm_pkg::*;

    logic signed [MUL_P_W-1:0] r_prod;

    // one registered signed product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    assign o_prod = r_prod;

endmodule

### rtl/tnm_mem.sv
module tnm_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tnm_pkg::t_mem_req i_req,
    output logic signed [15:0] o_weight,
    output logic signed [15:0] o_change
);
    import tnm_pkg::*;

    logic [31:0]           r_mem [0:MAX_INPUTS-1];
    logic [MAX_INPUTS-1:0] r_valid;
    logic [31:0]           r_rd_data;
    logic                  r_rd_valid;

    // weight and last change share one row
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= {i_req.weight, i_req.change};
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    // change reads as zero until the row is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.addr];
            end
        end
    end

    assign o_weight = signed'(r_rd_data[31:16]);
    assign o_change = r_rd_valid ? signed'(r_rd_data[15:0]) : 16'sd0;

endmodule

### rtl/tnm_seq.sv
module tnm_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [2:0]                         i_op,
    input  logic [5:0]                         i_index,
    input  logic signed [15:0]                 i_sample_value,
    input  logic signed [15:0]                 i_partner_gradient,
    input  logic                               i_last,
    input  logic [12:0]                        i_lr,
    input  logic [12:0]                        i_mom,
    output logic                               o_busy,
    output logic                               o_res_valid,
    output logic [1:0]                         o_res_kind,
    output logic signed [15:0]                 o_res_value,
    output tnm_pkg::t_mem_req                  o_mem_req,
    input  logic signed [15:0]                 i_weight,
    input  logic signed [15:0]                 i_change,
    output tnm_pkg::t_mul_req                  o_mul_req,
    input  logic signed [tnm_pkg::MUL_P_W-1:0] i_prod
);
    import tnm_pkg::*;

    localparam int P_W = 40 + TANH_LOG2 - 2;

    function automatic logic signed [15:0] sat16(input logic signed [59:0] v);
        logic signed [15:0] res;
        if (v > 60'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -60'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // round to nearest, ties away from zero, drop 24 bits
    function automatic logic signed [59:0] rnd24(input logic signed [59:0] v);
        logic signed [59:0] t;
        t = v + (v[59] ? 60'sd8388607 : 60'sd8388608);
        return t >>> 24;
    endfunction

    t_state r_state, n_state;

    logic [2:0]         r_op;
    logic [5:0]         r_index;
    logic               r_ok;
    logic signed [15:0] r_x;
    logic signed [15:0] r_pg;
    logic               r_last;

    logic signed [39:0] r_acc, n_acc;
    logic signed [15:0] r_act, n_act;
    logic signed [15:0] r_grad, n_grad;

    logic signed [27:0] r_gb;
    logic signed [31:0] r_oms;
    logic signed [45:0] r_sum;
    logic signed [15:0] r_d;

    logic [SEG_W-1:0]   r_seg;
    logic [23:0]        r_frac;
    logic               r_neg;
    logic [TAB_W-1:0]   r_ta;
    logic [TAB_W-1:0]   r_tb;

    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_kind, n_out_kind;
    logic signed [15:0] r_out_value, n_out_value;

    logic signed [40:0] acc_sum;
    logic signed [39:0] acc_sat;
    logic [39:0]        mag;
    logic [P_W-1:0]     tp;
    logic [P_W-25:0]    tseg;
    logic signed [13:0] tdiff;
    logic signed [59:0] tcorr;
    logic signed [13:0] ty;
    logic signed [15:0] act_val;
    logic signed [40:0] rnd12_in;
    logic signed [27:0] acc_rnd;
    logic signed [15:0] grad_val;
    logic signed [46:0] mterm;
    logic signed [46:0] dsum;
    logic signed [15:0] d_val;
    logic signed [16:0] w_sum;
    logic signed [15:0] w_val;
    logic signed [15:0] w_eff;

    // datapath arithmetic around the shared product
    always_comb begin
        acc_sum  = 41'(r_acc) + 41'(signed'(i_prod[31:0]));
        acc_sat  = (acc_sum[40] != acc_sum[39])
                 ? (acc_sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}})
                 : acc_sum[39:0];
        mag      = r_acc[39] ? 40'(-r_acc) : 40'(r_acc);
        tp       = P_W'(mag) << (TANH_LOG2 - 2);
        tseg     = tp[P_W-1:24];
        tdiff    = signed'({1'b0, r_tb}) - signed'({1'b0, r_ta});
        tcorr    = (i_prod + 60'sd8388608) >>> 24;
        ty       = signed'({1'b0, r_ta}) + 14'(tcorr);
        act_val  = r_neg ? -16'(ty) : 16'(ty);
        rnd12_in = 41'(r_acc) + (r_acc[39] ? 41'sd2047 : 41'sd2048);
        acc_rnd  = 28'(rnd12_in >>> 12);
        grad_val = sat16(rnd24(i_prod));
        mterm    = 47'(i_prod) <<< 12;
        dsum     = 47'(r_sum) + mterm;
        d_val    = sat16(rnd24(60'(dsum)));
        w_sum    = 17'(i_weight) + 17'(r_d);
        w_val    = sat16(60'(w_sum));
        w_eff    = r_ok ? i_weight : 16'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_act       <= '0;
            r_grad      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
            r_act       <= n_act;
            r_grad      <= n_grad;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_acc          = r_acc;
        n_act          = r_act;
        n_grad         = r_grad;
        n_out_valid    = 1'b0;
        n_out_kind     = KIND_ACT;
        n_out_value    = '0;
        o_mem_req      = '0;
        o_mem_req.addr = ADDR_W'(r_index);
        o_mul_req      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                unique case (r_op)
                    OP_LOAD: begin
                        o_mem_req.wr_en  = r_ok;
                        o_mem_req.weight = r_x;
                        o_mem_req.change = '0;
                        n_state          = S_IDLE;
                    end
                    OP_FWD, OP_HGRAD: begin
                        o_mem_req.rd_en = r_ok;
                        n_state         = S_MAC;
                    end
                    OP_OGRAD: begin
                        n_state = S_SQ;
                    end
                    OP_UPDATE: begin
                        o_mem_req.rd_en = r_ok;
                        n_state         = r_ok ? S_XG : S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MAC: begin
                o_mul_req.a = 32'((r_op == OP_FWD) ? w_eff : r_x);
                o_mul_req.b = 28'((r_op == OP_FWD) ? r_x : r_pg);
                n_state     = S_ACC;
            end
            S_ACC: begin
                n_acc = acc_sat;
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_op == OP_FWD) begin
                    n_state = S_TSEG;
                end else begin
                    n_state = S_RND;
                end
            end
            S_TSEG: begin
                n_acc   = '0;
                n_state = S_TA;
            end
            S_TA: begin
                n_state = S_TB;
            end
            S_TB: begin
                n_state = S_TMUL;
            end
            S_TMUL: begin
                o_mul_req.a = 32'(tdiff);
                o_mul_req.b = 28'(signed'({1'b0, r_frac}));
                n_state     = S_TOUT;
            end
            S_TOUT: begin
                n_act       = act_val;
                n_out_valid = 1'b1;
                n_out_kind  = KIND_ACT;
                n_out_value = act_val;
                n_state     = S_IDLE;
            end
            S_RND: begin
                n_acc   = '0;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_mul_req.a = 32'(r_act);
                o_mul_req.b = 28'(r_act);
                n_state     = S_OMS;
            end
            S_OMS: begin
                n_state = S_GMUL;
            end
            S_GMUL: begin
                o_mul_req.a = r_oms;
                o_mul_req.b = r_gb;
                n_state     = S_GOUT;
            end
            S_GOUT: begin
                n_grad      = grad_val;
                n_out_valid = 1'b1;
                n_out_kind  = KIND_GRAD;
                n_out_value = grad_val;
                n_state     = S_IDLE;
            end
            S_XG: begin
                o_mul_req.a = 32'(r_x);
                o_mul_req.b = 28'(r_grad);
                n_state     = S_LR;
            end
            S_LR: begin
                o_mul_req.a = signed'(i_prod[31:0]);
                o_mul_req.b = 28'(signed'({1'b0, i_lr}));
                n_state     = S_MOM;
            end
            S_MOM: begin
                o_mul_req.a = 32'(i_change);
                o_mul_req.b = 28'(signed'({1'b0, i_mom}));
                n_state     = S_DADD;
            end
            S_DADD: begin
                n_state = S_WB;
            end
            S_WB: begin
                o_mem_req.wr_en  = 1'b1;
                o_mem_req.weight = w_val;
                o_mem_req.change = r_d;
                n_out_valid      = 1'b1;
                n_out_kind       = KIND_WEIGHT;
                n_out_value      = w_val;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_op    <= i_op;
                    r_index <= i_index;
                    r_ok    <= 32'(i_index) < MAX_INPUTS;
                    r_x     <= i_sample_value;
                    r_pg    <= i_partner_gradient;
                    r_last  <= i_last;
                end
            end
            S_TSEG: begin
                r_neg <= r_acc[39];
                if (tseg >= (P_W - 24)'(TANH_N)) begin
                    r_seg  <= SEG_W'(TANH_N);
                    r_frac <= '0;
                end else begin
                    r_seg  <= SEG_W'(tseg);
                    r_frac <= tp[23:0];
                end
            end
            S_TA: begin
                r_ta <= TANH_TAB[r_seg];
                if (r_seg != SEG_W'(TANH_N)) begin
                    r_seg <= r_seg + SEG_W'(1);
                end
            end
            S_TB: begin
                r_tb <= TANH_TAB[r_seg];
            end
            S_RND: begin
                r_gb <= acc_rnd;
            end
            S_SQ: begin
                if (r_op == OP_OGRAD) begin
                    r_gb <= 28'(17'(r_x) - 17'(r_act));
                end
            end
            S_OMS: begin
                r_oms <= 32'sd16777216 - signed'(i_prod[31:0]);
            end
            S_MOM: begin
                r_sum <= 46'(i_prod);
            end
            S_DADD: begin
                r_d <= d_val;
            end
            default: begin
            end
        endcase
        if (n_out_valid) begin
            r_out_kind  <= n_out_kind;
            r_out_value <= n_out_value;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res_kind  = r_out_kind;
    assign o_res_value = r_out_value;

endmodule

### rtl/tanh_neuron_momentum_backprop.sv
// tanh neuron with momentum backpropagation, Q3.12 fixed point
//
// command channel: an item is taken at a rising edge with start high and busy
// low; op, index, sample_value, partner_gradient and last travel with it.
// busy stays high while the item is worked on; nothing is taken meanwhile.
// result channel: o_result_strobe is high for exactly one cycle with
// o_result_kind / o_result_value; the receiver cannot stall, it must take it.
// a result strobe shows in the cycle busy drops, so a new item may be started
// in that same cycle; a load or a non-last element gives no result.
// the work runs on the one shared 32x28 multiplier (one product per cycle,
// registered) and the registered weight/change memory read; tanh
// interpolation takes two table reads and one product.
// configuration: APB, learning_rate at 0x0, momentum at 0x4, pready always
// high; write only while busy is low.
// reset (synchronous, active low): registers back to 0.2 and 0.5,
// accumulator, activation and gradient cleared, all stored changes read as
// zero at once (valid bit per row); weights stay undefined until loaded.
module tanh_neuron_momentum_backprop (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_op,
    input  logic [5:0]         i_index,
    input  logic signed [15:0] i_sample_value,
    input  logic signed [15:0] i_partner_gradient,
    input  logic               i_last,
    // result channel
    output logic               o_result_strobe,
    output logic [1:0]         o_result_kind,
    output logic signed [15:0] o_result_value
);
    import tnm_pkg::*;

    localparam logic [12:0] LR_RESET  = 13'd819;
    localparam logic [12:0] MOM_RESET = 13'd2048;

    logic [12:0] r_lr;
    logic [12:0] r_mom;
    logic        cfg_wr;

    t_mem_req                  mem_req;
    logic signed [15:0]        mem_weight;
    logic signed [15:0]        mem_change;
    t_mul_req                  mul_req;
    logic signed [MUL_P_W-1:0] mul_prod;

    // apb write completes in the access phase; paddr[2] selects the register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= LR_RESET;
            r_mom <= MOM_RESET;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_mom <= pwdata[12:0];
            end else begin
                r_lr <= pwdata[12:0];
            end
        end
    end

    // readback, zero-extended
    assign prdata = paddr[2] ? 32'(r_mom) : 32'(r_lr);

    // sequencer and datapath: owns accumulator, activation, gradient
    tnm_seq u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_op               (i_op),
        .i_index            (i_index),
        .i_sample_value     (i_sample_value),
        .i_partner_gradient (i_partner_gradient),
        .i_last             (i_last),
        .i_lr               (r_lr),
        .i_mom              (r_mom),
        .o_busy             (busy),
        .o_res_valid        (o_result_strobe),
        .o_res_kind         (o_result_kind),
        .o_res_value        (o_result_value),
        .o_mem_req          (mem_req),
        .i_weight           (mem_weight),
        .i_change           (mem_change),
        .o_mul_req          (mul_req),
        .i_prod             (mul_prod)
    );

    // weight and change store, one port, registered read
    tnm_mem u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mem_req),
        .o_weight (mem_weight),
        .o_change (mem_change)
    );

    // the one multiplier that every op but load shares
    tnm_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    // an accepted item always leaves the idle state
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result only follows work in progress
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // at most one result per item, never two in a row
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe held longer than one cycle");

endmodule
